### rtl/cct_pkg.sv
`default_nettype none

package cct_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int TSIZE_W       = 11;
  localparam int LIVE_W        = (IDX_W + 1 > TSIZE_W) ? IDX_W + 1 : TSIZE_W;
  localparam int WORD_W        = 32;

  localparam logic [WORD_W-1:0] END_OF_CHAIN = 32'hFFFF_FFFF;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd1;

  // reset values of the registers
  localparam logic [WORD_W-1:0]  DATA_START_RST = 32'd2;
  localparam logic [TSIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_FREE  = 3'd2,
    KIND_APPND = 3'd3,
    KIND_LAST  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_INVALID  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ_WAIT,
    S_WALK_WAIT,
    S_SCAN,
    S_APP_LINK,
    S_APP_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [WORD_W-1:0] cluster;
    logic [WORD_W-1:0] next_value;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    status_t           status;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/cct_req_if.sv
`default_nettype none

interface cct_req_if import cct_pkg::*;;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/cct_rsp_if.sv
`default_nettype none

interface cct_rsp_if import cct_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/cluster_chain_table.sv
// cluster_chain_table: cluster allocation table with one 32-bit next-cluster
// word per data cluster (0 free, all ones end of chain).
// req channel (valid/ready): kind, cluster, next_value. rsp channel: value,
// status. Exactly one rsp item for every req item, in order.
// cfg port: cfg_we/cfg_index/cfg_data, index 0 data_region_start, index 1
// table_size; write only while no item is in flight.
// One item at a time, on a single-port table memory driven by a small
// sequencer. Find-free scans one entry per cycle; append scans the same way
// and then writes the link and the end mark; find-last reads one entry per
// link and stops at the end mark, a bad link or the step limit of live size
// links. The next item is taken in the cycle after the result enters the
// output register.
// After reset the memory is swept to zero, one entry per cycle, over all
// TABLE_ENTRIES (1024) entries; req.ready stays low during the sweep while
// cfg writes are taken as usual.
// The result sits in an output register: a new item can be accepted while a
// result waits; if the receiver stalls, the next item finishes and then waits
// until the output register is free.
`default_nettype none

module cluster_chain_table import cct_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  cct_req_if.sink                   req,
  cct_rsp_if.source                 rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  // configuration registers
  logic [WORD_W-1:0]  data_start;
  logic [TSIZE_W-1:0] table_size;
  logic [LIVE_W-1:0]  live_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_start <= DATA_START_RST;
      table_size <= TABLE_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_START: data_start <= cfg_data;
        CFG_TABLE_SIZE: table_size <= cfg_data[TSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // entries in use, capped at the table depth
  assign live_size = (LIVE_W'(table_size) > LIVE_W'(TABLE_ENTRIES)) ?
                     LIVE_W'(TABLE_ENTRIES) : LIVE_W'(table_size);

  // table memory
  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // sequencer registers
  state_t            state, state_next;
  logic [IDX_W-1:0]  clr_addr, clr_addr_next;
  logic [2:0]        kind_r, kind_r_next;
  logic [WORD_W-1:0] cur, cur_next;
  logic [WORD_W-1:0] nv_r, nv_r_next;
  logic [IDX_W-1:0]  link_idx, link_idx_next;
  logic [IDX_W-1:0]  free_idx, free_idx_next;
  logic [LIVE_W-1:0] scan_addr, scan_addr_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic [LIVE_W-1:0] steps, steps_next;
  logic [WORD_W-1:0] res_value, res_value_next;
  status_t           res_status, res_status_next;
  logic              rsp_valid, rsp_valid_next;
  rsp_t              rsp_data, rsp_data_next;

  // shared address check: subtract and range compare
  logic [WORD_W:0]   diff;
  logic              in_range;
  logic [WORD_W-1:0] found_value;

  assign diff        = {1'b0, cur} - {1'b0, data_start};
  assign in_range    = !diff[WORD_W] && (diff[WORD_W-1:0] < WORD_W'(live_size));
  assign found_value = WORD_W'(pend_idx) + data_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_r_next;
    cur        <= cur_next;
    nv_r       <= nv_r_next;
    link_idx   <= link_idx_next;
    free_idx   <= free_idx_next;
    scan_addr  <= scan_addr_next;
    pend       <= pend_next;
    pend_idx   <= pend_idx_next;
    steps      <= steps_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    rsp_data   <= rsp_data_next;
  end

  // next state and memory control
  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    kind_r_next     = kind_r;
    cur_next        = cur;
    nv_r_next       = nv_r;
    link_idx_next   = link_idx;
    free_idx_next   = free_idx;
    scan_addr_next  = scan_addr;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    steps_next      = steps;
    res_value_next  = res_value;
    res_status_next = res_status;
    rsp_data_next   = rsp_data;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    mem_we          = 1'b0;
    mem_addr        = diff[IDX_W-1:0];
    mem_wdata       = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_addr      = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          kind_r_next    = req.data.kind;
          cur_next       = req.data.cluster;
          nv_r_next      = req.data.next_value;
          steps_next     = '0;
          scan_addr_next = '0;
          pend_next      = 1'b0;
          state_next     = S_CHECK;
        end
      end

      // validate the cluster and dispatch on kind
      S_CHECK: begin
        res_value_next  = '0;
        res_status_next = ST_OK;
        link_idx_next   = diff[IDX_W-1:0];
        state_next      = S_DONE;
        case (kind_r)
          KIND_READ: begin
            if (in_range) begin
              state_next = S_READ_WAIT;
            end else begin
              res_status_next = ST_INVALID;
            end
          end
          KIND_WRITE: begin
            if (in_range) begin
              mem_we    = 1'b1;
              mem_wdata = nv_r;
            end else begin
              res_status_next = ST_INVALID;
            end
          end
          KIND_FREE: begin
            state_next = S_SCAN;
          end
          KIND_APPND: begin
            if (in_range) begin
              state_next = S_SCAN;
            end else begin
              res_status_next = ST_INVALID;
            end
          end
          KIND_LAST: begin
            if (live_size == '0) begin
              res_status_next = ST_INVALID;
            end else if (steps == live_size) begin
              res_status_next = ST_TOO_LONG;
            end else if (!in_range) begin
              res_status_next = ST_INVALID;
            end else begin
              state_next = S_WALK_WAIT;
            end
          end
          default: ;
        endcase
      end

      S_READ_WAIT: begin
        res_value_next = mem_rdata;
        state_next     = S_DONE;
      end

      // one link of a chain walk
      S_WALK_WAIT: begin
        steps_next = steps + 1'b1;
        if (mem_rdata == END_OF_CHAIN) begin
          res_value_next = cur;
          state_next     = S_DONE;
        end else begin
          cur_next   = mem_rdata;
          state_next = S_CHECK;
        end
      end

      // free scan, one read issued and one entry tested per cycle
      S_SCAN: begin
        mem_addr = scan_addr[IDX_W-1:0];
        if (pend && mem_rdata == '0) begin
          res_value_next = found_value;
          free_idx_next  = pend_idx;
          state_next     = (kind_r == KIND_APPND) ? S_APP_LINK : S_DONE;
        end else if (scan_addr < live_size) begin
          pend_next      = 1'b1;
          pend_idx_next  = scan_addr[IDX_W-1:0];
          scan_addr_next = scan_addr + 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          res_value_next  = END_OF_CHAIN;
          res_status_next = ST_FULL;
          state_next      = S_DONE;
        end
      end

      S_APP_LINK: begin
        mem_we     = 1'b1;
        mem_addr   = link_idx;
        mem_wdata  = res_value;
        state_next = S_APP_END;
      end

      // second write wins when the free entry is the linked one
      S_APP_END: begin
        mem_we     = 1'b1;
        mem_addr   = free_idx;
        mem_wdata  = END_OF_CHAIN;
        state_next = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_data_next.value  = res_value;
          rsp_data_next.status = res_status;
          rsp_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

`ifndef NO_ASSERTIONS
  // a chain walk never reads more links than the live size
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_WAIT) |-> (steps < live_size))
    else $error("chain walk ran past live size");

  // the free scan address never runs past the live size
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_addr <= live_size))
    else $error("free scan ran past live size");

  // a new result only ever comes from the done state
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !$past(rsp.valid)) |-> ($past(state) == S_DONE))
    else $error("result loaded outside done state");
`endif

endmodule

`default_nettype wire

### dv/tb_cluster_chain_table.sv
`timescale 1ns / 1ps

module tb_cluster_chain_table;
  import cct_pkg::*;

  // kinds outside the defined operations, taken as no-ops
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // slowest quiet stretch: the reset sweep, or a 1024-link walk
  // stacked on a long receiver hold; limit is several times that
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1080;

  // mirror of the link table plus the queue of replies it predicts
  class link_table_board;
    logic [WORD_W-1:0]  links [TABLE_ENTRIES];
    logic [WORD_W-1:0]  region_start;
    logic [TSIZE_W-1:0] size_reg;
    rsp_t               expected_replies [$];
    rsp_t               last_reply;
    int                 mismatches;
    int                 checked;
    int                 kind_seen [8];
    int                 status_seen [4];

    function new();
      foreach (links[i]) links[i] = '0;
      region_start      = DATA_START_RST;
      size_reg          = TABLE_SIZE_RST;
      last_reply.value  = '0;
      last_reply.status = ST_OK;
      mismatches        = 0;
      checked           = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
      if (idx == CFG_DATA_START) region_start = val;
      else size_reg = val[TSIZE_W-1:0];
    endfunction

    // table size saturates at the physical depth
    function int unsigned live_entries();
      return (size_reg > TABLE_ENTRIES) ? TABLE_ENTRIES : size_reg;
    endfunction

    function bit index_of(logic [WORD_W-1:0] cl, output int unsigned idx);
      logic [WORD_W-1:0] d;
      idx = 0;
      if (cl < region_start) return 1'b0;
      d = cl - region_start;
      if (d >= live_entries()) return 1'b0;
      idx = d;
      return 1'b1;
    endfunction

    function bit lowest_free(output int unsigned idx);
      int unsigned n;
      n   = live_entries();
      idx = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (links[i] == '0) begin
          idx = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // one operation on the mirror, returns the reply it should produce
    function rsp_t predict_reply(req_t r);
      rsp_t              res;
      int unsigned       idx, fidx, steps, n;
      logic [WORD_W-1:0] cur, nxt;
      res.value  = '0;
      res.status = ST_OK;
      n          = live_entries();
      case (r.kind)
        KIND_READ: begin
          if (index_of(r.cluster, idx)) res.value = links[idx];
          else res.status = ST_INVALID;
        end
        KIND_WRITE: begin
          if (index_of(r.cluster, idx)) links[idx] = r.next_value;
          else res.status = ST_INVALID;
        end
        KIND_FREE: begin
          if (lowest_free(fidx)) begin
            res.value = region_start + fidx;
          end else begin
            res.value  = END_OF_CHAIN;
            res.status = ST_FULL;
          end
        end
        KIND_APPND: begin
          if (!index_of(r.cluster, idx)) begin
            res.status = ST_INVALID;
          end else if (!lowest_free(fidx)) begin
            res.value  = END_OF_CHAIN;
            res.status = ST_FULL;
          end else begin
            // end-of-chain mark goes last, so it wins when the free one is the start
            res.value   = region_start + fidx;
            links[idx]  = res.value;
            links[fidx] = END_OF_CHAIN;
          end
        end
        KIND_LAST: begin
          cur        = r.cluster;
          steps      = 0;
          res.status = ST_TOO_LONG;
          while (steps < n) begin
            if (!index_of(cur, idx)) begin
              res.status = ST_INVALID;
              break;
            end
            nxt = links[idx];
            steps++;
            if (nxt == END_OF_CHAIN) begin
              res.value  = cur;
              res.status = ST_OK;
              break;
            end
            cur = nxt;
          end
          if (n == 0) res.status = ST_INVALID;
          if (res.status != ST_OK) res.value = '0;
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_request(req_t r);
      last_reply = predict_reply(r);
      expected_replies.push_back(last_reply);
      kind_seen[r.kind]++;
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch on reply %0d: %s", $time, checked, msg);
    endtask

    task check_reply(rsp_t got);
      rsp_t want;
      checked++;
      status_seen[got.status]++;
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("value %h status %0d with no request pending",
                                  got.value, got.status));
        return;
      end
      want = expected_replies.pop_front();
      if (got.value !== want.value)
        report_mismatch($sformatf("value %h, want %h", got.value, want.value));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  cct_req_if req_ch ();
  cct_rsp_if rsp_ch ();

  link_table_board board = new();

  int                burst_left;
  int                idle_cycles = 0;
  int                hold_left   = 0;
  bit                hold_request = 1'b0;
  int                pat_age     = 0;
  logic [7:0]        stall_pat   = 8'hFF;
  logic [WORD_W-1:0] chain_head, chain_tail;

  cluster_chain_table dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      board.check_reply(rsp_ch.data);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no handshake for %0d cycles, run stopped", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: rotating stall pattern, plus one long hold on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (pat_age == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = 8'hFF;
            1: stall_pat = 8'($urandom);
            2: stall_pat = ~(8'h01 << $urandom_range(0, 7));
            default: stall_pat = 8'h01 << $urandom_range(0, 7);
          endcase
          pat_age = $urandom_range(16, 96);
        end
        pat_age--;
        rsp_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    end
  end

  // write both registers back to back, enable held across the pair
  task automatic configure(logic [WORD_W-1:0] start, logic [TSIZE_W-1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DATA_START;
    cfg_data  <= start;
    @(posedge clk);
    board.apply_reg(CFG_DATA_START, start);
    cfg_index <= CFG_TABLE_SIZE;
    cfg_data  <= WORD_W'(size);
    @(posedge clk);
    board.apply_reg(CFG_TABLE_SIZE, WORD_W'(size));
    cfg_we <= 1'b0;
  endtask

  // offer one item, hold until taken; bursts end in a random gap
  task automatic offer(req_t it);
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(it);
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic issue(logic [2:0] kind, logic [WORD_W-1:0] cl, logic [WORD_W-1:0] nv);
    req_t it;
    it.kind       = kind;
    it.cluster    = cl;
    it.next_value = nv;
    offer(it);
  endtask

  // stop offering and let every reply come home
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] any_valid();
    int unsigned n;
    n = board.live_entries();
    if (n == 0) return $urandom;
    return board.region_start + $urandom_range(0, n - 1);
  endfunction

  // chain building and walking, reads, writes and scans, mostly on valid clusters, some noise
  task automatic pick_random_item(output req_t it);
    int unsigned       roll, n;
    logic [WORD_W-1:0] base;
    n             = board.live_entries();
    base          = board.region_start;
    roll          = $urandom_range(0, 99);
    it.kind       = KIND_READ;
    it.cluster    = any_valid();
    it.next_value = $urandom;
    if ($urandom_range(0, 24) == 0) begin
      chain_head = any_valid();
      chain_tail = chain_head;
    end
    // a full table gets a cluster freed half the time
    if (board.last_reply.status == ST_FULL && $urandom_range(0, 1) == 1) begin
      it.kind       = KIND_WRITE;
      it.next_value = '0;
    end else if (roll < 22) begin
      it.kind = KIND_APPND;
      if (roll < 16) it.cluster = chain_tail;
    end else if (roll < 44) begin
      it.kind = KIND_LAST;
      if (roll < 36) it.cluster = chain_head;
    end else if (roll < 56) begin
      it.kind = KIND_READ;
    end else if (roll < 70) begin
      it.kind = KIND_WRITE;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: it.next_value = '0;
        4, 5:       it.next_value = END_OF_CHAIN;
        6, 7, 8:    it.next_value = any_valid();
        default:    it.next_value = $urandom;
      endcase
    end else if (roll < 80) begin
      it.kind    = KIND_FREE;
      it.cluster = $urandom;
    end else if (roll < 84) begin
      it.kind    = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      it.cluster = $urandom;
    end else begin
      it.kind = 3'($urandom_range(KIND_READ, KIND_LAST));
      case ($urandom_range(0, 5))
        0:       it.cluster = base - 1;
        1:       it.cluster = base + n;
        2:       it.cluster = base + n - 1;
        3:       it.cluster = '0;
        4:       it.cluster = '1;
        default: it.cluster = $urandom;
      endcase
    end
  endtask

  initial begin
    req_t              it;
    int                counted, phase, quota, done_here;
    logic [WORD_W-1:0] start;
    logic [TSIZE_W-1:0] size;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_DATA_START;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    burst_left   = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // small table from cluster 1: chain growth, full table, loop, broken link
    configure(32'd1, 11'd4);
    issue(KIND_READ, 32'd1, '0);
    issue(KIND_READ, 32'd0, '0);
    issue(KIND_FREE, '0, '0);
    issue(KIND_APPND, 32'd1, '0);
    issue(KIND_APPND, 32'd1, '0);
    issue(KIND_APPND, 32'd2, '0);
    issue(KIND_LAST, 32'd1, '0);
    issue(KIND_APPND, 32'd3, '0);
    issue(KIND_FREE, '0, '0);
    issue(KIND_APPND, 32'd4, '0);
    issue(KIND_WRITE, 32'd4, 32'd1);
    issue(KIND_LAST, 32'd1, '0);
    issue(KIND_WRITE, 32'd3, '0);
    issue(KIND_LAST, 32'd1, '0);
    issue(KIND_WRITE, '1, '1);
    issue(KIND_SPARE_HI, '1, '1);
    drain();

    // highest start with an oversized size, self loop over the whole table
    configure(32'd4294966271, 11'd2047);
    issue(KIND_FREE, '0, '0);
    issue(KIND_READ, '1, '0);
    issue(KIND_APPND, 32'hFFFF_FFFE, '0);
    issue(KIND_LAST, 32'hFFFF_FFFE, '0);
    issue(KIND_WRITE, 32'd4294966271 + 32'd1000, 32'd4294966271 + 32'd1000);
    issue(KIND_LAST, 32'd4294966271 + 32'd1000, '0);
    drain();

    // empty table
    configure(32'd0, 11'd0);
    issue(KIND_APPND, 32'd5, '0);
    issue(KIND_LAST, '0, '0);
    issue(KIND_FREE, '0, '0);
    drain();

    // table window that would run past all ones
    configure(32'hFFFF_FFFC, 11'd8);
    issue(KIND_FREE, '0, '0);
    issue(KIND_APPND, '1, '0);
    issue(KIND_LAST, '1, '0);
    drain();

    // random phases, each with its own table window
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       start = 32'd1;
        1:       start = 32'd4294966271;
        2:       start = $urandom_range(1, 32'd4294966271);
        3:       start = 32'hFFFF_FFF0;
        default: start = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 19))
        0: begin
          size  = 11'd1024;
          quota = 30;
        end
        1: begin
          size  = 11'($urandom_range(1025, 2047));
          quota = 30;
        end
        2: begin
          size  = 11'd0;
          quota = 8;
        end
        3: begin
          size  = 11'd1;
          quota = 40;
        end
        4: begin
          size  = 11'd2;
          quota = 60;
        end
        default: begin
          size  = 11'($urandom_range(3, 48));
          quota = 90;
        end
      endcase
      configure(start, size);
      if (phase == 1) hold_request = 1'b1;
      chain_head = any_valid();
      chain_tail = chain_head;
      done_here  = 0;
      while (done_here < quota && counted < RANDOM_ITEMS) begin
        pick_random_item(it);
        offer(it);
        if (it.kind == KIND_APPND && it.cluster == chain_tail &&
            board.last_reply.status == ST_OK)
          chain_tail = board.last_reply.value;
        if (it.kind <= KIND_LAST) begin
          counted++;
          done_here++;
        end
      end
      drain();
      phase++;
    end

    // tail wait for anything stray
    repeat (40) @(posedge clk);

    $display("covered %0d requests in %0d table settings: %0d read, %0d write,",
             board.checked, phase + 4, board.kind_seen[KIND_READ],
             board.kind_seen[KIND_WRITE]);
    $display("  %0d scan, %0d append, %0d walk, %0d unused kind",
             board.kind_seen[KIND_FREE], board.kind_seen[KIND_APPND],
             board.kind_seen[KIND_LAST],
             board.kind_seen[5] + board.kind_seen[6] + board.kind_seen[7]);
    $display("replies: %0d ok, %0d table full, %0d invalid cluster,",
             board.status_seen[ST_OK], board.status_seen[ST_FULL],
             board.status_seen[ST_INVALID]);
    $display("  %0d chain too long, %0d mismatches",
             board.status_seen[ST_TOO_LONG], board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
